// ===== src/salru_pkg.sv =====
package salru_pkg;

  localparam int unsigned LINE_BYTES_DEF  = 64;
  localparam int unsigned TOTAL_LINES_DEF = 8192;
  localparam int unsigned WAYS_DEF        = 16;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 7;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK_A,
    S_LOOK_B,
    S_FIN
  } state_t;

endpackage

// ===== src/salru_set_update.sv =====
module salru_set_update #(
  parameter int unsigned WAYS  = 16,
  parameter int unsigned TAG_W = 49
) (
  input  logic [WAYS-1:0][TAG_W-1:0] row_in,
  input  logic [TAG_W-1:0]           tag,
  output logic [WAYS-1:0][TAG_W-1:0] row_out,
  output logic                       hit
);

  logic [WAYS-1:0] match;
  // seen[w]: some way below w already matched, so way w keeps its tag
  logic [WAYS-1:0] seen;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (row_in[w] == tag);
    end
    seen[0] = 1'b0;
    for (int w = 1; w < WAYS; w++) begin
      seen[w] = seen[w-1] | match[w-1];
    end
    hit = |match;
    row_out[0] = tag;
    for (int w = 1; w < WAYS; w++) begin
      row_out[w] = seen[w] ? row_in[w] : row_in[w-1];
    end
  end

endmodule

// ===== src/set_assoc_lru_cache_model_core.sv =====
// channel   direction  handshake            payload
// request   in         in_valid / in_stall  command, address, access_size
// result    out        out_valid / out_stall hit, straddled
//
// an access steps through accept, row read-modify-write and result, with a second
// set memory row read-modify-write when it straddles two sets, one per set touched
// a flush sweeps the set memory one row per cycle, clearing all SETS rows (512 by default)
// after reset the same clearing pass runs before the first request
// a finished result waits in the output register while the next request is taken;
// a result that finds the output register still full waits until out_stall drops
module set_assoc_lru_cache_model_core #(
  parameter int unsigned LINE_BYTES  = salru_pkg::LINE_BYTES_DEF,
  parameter int unsigned TOTAL_LINES = salru_pkg::TOTAL_LINES_DEF,
  parameter int unsigned WAYS        = salru_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [salru_pkg::ADDR_W-1:0]  address,
  input  logic [salru_pkg::SIZE_W-1:0]  access_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic                          straddled
);
  import salru_pkg::*;

  localparam int unsigned OFS_W    = $clog2(LINE_BYTES);
  localparam int unsigned SETS_RAW = TOTAL_LINES / WAYS;
  localparam int unsigned SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int unsigned SET_W    = $clog2(SETS);
  localparam int unsigned SET_IW   = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned TAG_W    = ADDR_W - OFS_W - SET_W;
  localparam int unsigned ROW_W    = WAYS * TAG_W;

  state_t state, state_next;

  logic [SET_IW-1:0] set_a, set_b, clr_idx;
  logic [TAG_W-1:0]  tag_a, tag_b;
  logic              straddle, hit_acc, flush_pend;

  logic [ADDR_W-1:0] end_addr, line_first, line_last;
  logic [SET_IW-1:0] req_set_a, req_set_b;
  logic [TAG_W-1:0]  req_tag_a, req_tag_b;
  logic              accept, clr_last;

  logic [ROW_W-1:0]  tag_mem [SETS];
  logic [ROW_W-1:0]  mem_rdata, mem_wdata;
  logic [SET_IW-1:0] mem_raddr, mem_waddr;
  logic              mem_re, mem_we;

  logic [WAYS-1:0][TAG_W-1:0] upd_row;
  logic [TAG_W-1:0]           upd_tag;
  logic                       upd_hit;
  logic                       out_load;

  assign accept = in_valid && !in_stall;

  // line numbers of the first and last byte, the last wrapping modulo 2^64
  assign end_addr   = address + ADDR_W'(access_size) - ADDR_W'(1);
  assign line_first = address >> OFS_W;
  assign line_last  = end_addr >> OFS_W;
  assign req_set_a  = SET_IW'(line_first % SETS);
  assign req_set_b  = SET_IW'(line_last % SETS);
  assign req_tag_a  = TAG_W'(line_first >> SET_W);
  assign req_tag_b  = TAG_W'(line_last >> SET_W);

  assign clr_last = (clr_idx == SET_IW'(SETS - 1));

  assign upd_tag = (state == S_LOOK_B) ? tag_b : tag_a;

  salru_set_update #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_update (
    .row_in  (mem_rdata),
    .tag     (upd_tag),
    .row_out (upd_row),
    .hit     (upd_hit)
  );

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = set_b;
    mem_waddr  = set_a;
    mem_wdata  = upd_row;
    out_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_last) begin
          state_next = flush_pend ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall  = 1'b0;
        mem_raddr = req_set_a;
        if (in_valid) begin
          if (command == CMD_FLUSH) begin
            state_next = S_CLEAR;
          end else begin
            mem_re     = 1'b1;
            state_next = S_LOOK_A;
          end
        end
      end
      S_LOOK_A: begin
        mem_we = 1'b1;
        if (straddle) begin
          mem_re     = 1'b1;
          state_next = S_LOOK_B;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LOOK_B: begin
        mem_we     = 1'b1;
        mem_waddr  = set_b;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      flush_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_last ? '0 : clr_idx + SET_IW'(1);
      end
      if (accept) begin
        flush_pend <= (command == CMD_FLUSH);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_a    <= req_set_a;
      set_b    <= req_set_b;
      tag_a    <= req_tag_a;
      tag_b    <= req_tag_b;
      straddle <= (req_set_a != req_set_b);
      hit_acc  <= 1'b0;
    end else if (state == S_LOOK_A) begin
      hit_acc <= upd_hit;
    end else if (state == S_LOOK_B) begin
      hit_acc <= hit_acc & upd_hit;
    end
    if (out_load) begin
      hit       <= flush_pend ? 1'b0 : hit_acc;
      straddled <= flush_pend ? 1'b0 : straddle;
    end
  end

  // one row per set, way 0 at the low end is the most recently used
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= tag_mem[mem_raddr];
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("set memory written while idle");

  a_access_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_ACCESS) |=> (state == S_LOOK_A && $past(mem_re)))
    else $error("access request did not start a row read");

  a_flush_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_FLUSH) |=> (state == S_CLEAR && clr_idx == '0))
    else $error("flush did not start the clearing pass at row zero");

  a_second_set: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK_B |-> (straddle && set_a != set_b))
    else $error("second lookup without two distinct sets");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    out_load |=> state == S_IDLE)
    else $error("result loaded without returning to idle");

endmodule

// ===== tb/tb_set_assoc_lru_cache_model_core.sv =====
module tb_set_assoc_lru_cache_model_core;
  timeunit 1ns;
  timeprecision 1ps;

  import salru_pkg::*;

  localparam int unsigned SETS =
    (TOTAL_LINES_DEF / WAYS_DEF) > 0 ? (TOTAL_LINES_DEF / WAYS_DEF) : 1;
  localparam int unsigned POOL_N = 20;

  typedef struct packed {
    logic hit;
    logic straddled;
  } lookup_res_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              typed;
    logic              hit;
    logic              strad;
  } dir_row_t;

  // typed rows carry the result that can be read off directly
  localparam dir_row_t DIRECTED [17] = '{
    '{CMD_ACCESS, 64'h0000_0000_0000_0000, 7'd1,   1'b1, 1'b1, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_003F, 7'd2,   1'b1, 1'b1, 1'b1},
    '{CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1,   1'b1, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd2,   1'b1, 1'b1, 1'b1},
    '{CMD_ACCESS, 64'h0000_0000_0000_0000, 7'd0,   1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_7FC0, 7'd127, 1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_8000, 7'd64,  1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_8001, 7'd64,  1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFC0, 7'd64,  1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h5555_5555_5555_5555, 7'h55,  1'b0, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA, 7'h2A,  1'b0, 1'b0, 1'b0},
    '{CMD_FLUSH,  64'h0000_0000_0000_0000, 7'd1,   1'b1, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1,   1'b1, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_8000, 7'd1,   1'b1, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'h0000_0000_0000_0000, 7'd1,   1'b1, 1'b1, 1'b0},
    '{CMD_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, 1'b0, 1'b0},
    '{CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1'b0, 1'b0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_ACCESS;
  logic [ADDR_W-1:0] address = '0;
  logic [SIZE_W-1:0] access_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              hit;
  logic              straddled;

  int          send_gap_pct = 31;
  int          stall_pct = 71;
  int          fail_count = 0;
  lookup_res_t expected_lookups [$];

  // recency-ordered tags per set, way 0 is most recent
  bit [63:0] lru_rows [SETS][WAYS_DEF];
  bit [63:0] tag_pool [POOL_N];

  set_assoc_lru_cache_model_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .address     (address),
    .access_size (access_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .straddled   (straddled)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  function automatic logic lru_touch(input int unsigned set_idx, input bit [63:0] tag);
    int   found;
    int   w;
    logic was_hit;
    found = WAYS_DEF - 1;
    was_hit = 1'b0;
    for (w = 0; w < WAYS_DEF; w++) begin
      if (!was_hit && lru_rows[set_idx][w] == tag) begin
        found = w;
        was_hit = 1'b1;
      end
    end
    for (w = found; w > 0; w--) lru_rows[set_idx][w] = lru_rows[set_idx][w-1];
    lru_rows[set_idx][0] = tag;
    return was_hit;
  endfunction

  function automatic lookup_res_t predict_lookup(input logic cmd, input logic [ADDR_W-1:0] addr,
                                                 input logic [SIZE_W-1:0] size);
    lookup_res_t r;
    bit [63:0]   first_line;
    bit [63:0]   last_line;
    int unsigned set_a;
    int unsigned set_b;
    logic        hit_a;
    logic        hit_b;
    r = '0;
    if (cmd == CMD_FLUSH) begin
      foreach (lru_rows[s, w]) lru_rows[s][w] = '0;
      return r;
    end
    first_line = addr / LINE_BYTES_DEF;
    // last byte wraps modulo 2^64, size zero lands on the previous byte
    last_line = (addr + 64'(size) - 64'd1) / LINE_BYTES_DEF;
    set_a = int'(first_line % SETS);
    set_b = int'(last_line % SETS);
    hit_a = lru_touch(set_a, first_line / SETS);
    if (set_a == set_b) begin
      r.hit = hit_a;
    end else begin
      hit_b = lru_touch(set_b, last_line / SETS);
      r.hit = hit_a & hit_b;
      r.straddled = 1'b1;
    end
    return r;
  endfunction

  task automatic issue_request(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [SIZE_W-1:0] size, input logic typed,
                               input lookup_res_t typed_res);
    lookup_res_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    access_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_lookup(cmd, addr, size);
    expected_lookups.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int                i;
    int                pick;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    bit [63:0]         set_idx;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      cmd = CMD_ACCESS;
      if (pick < 2) begin
        cmd = CMD_FLUSH;
        addr = {$urandom, $urandom};
        size = SIZE_W'($urandom_range(127));
      end else if (pick < 12) begin
        addr = {$urandom, $urandom};
        size = SIZE_W'($urandom_range(127));
      end else begin
        // small working set over adjacent sets around the wrap, more tags than ways
        set_idx = 64'(($urandom_range(5) + SETS - 2) % SETS);
        addr = (tag_pool[$urandom_range(POOL_N - 1)] * SETS + set_idx) * LINE_BYTES_DEF
               + $urandom_range(LINE_BYTES_DEF - 1);
        pick = $urandom_range(99);
        if (pick < 80) size = SIZE_W'($urandom_range(64, 1));
        else if (pick < 88) size = '0;
        else size = SIZE_W'($urandom_range(127, 65));
      end
      issue_request(cmd, addr, size, 1'b0, '0);
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  initial begin : stimulus
    int i;
    tag_pool[0] = '0;
    tag_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF / (SETS * LINE_BYTES_DEF);
    for (i = 2; i < POOL_N; i++) tag_pool[i] = {$urandom, $urandom} % tag_pool[1];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < $size(DIRECTED); i++) begin
      issue_request(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].size, DIRECTED[i].typed,
                    {DIRECTED[i].hit, DIRECTED[i].strad});
    end
    run_random(450);
    wait_drained();
    send_gap_pct = 71;
    stall_pct = 31;
    run_random(450);
    wait_drained();
    send_gap_pct = 0;
    stall_pct = 0;
    run_random(480);
    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && expected_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    lookup_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lookups.size() == 0) begin
        $error("result with no request outstanding: hit %0b straddled %0b", hit, straddled);
        fail_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (hit !== want.hit) begin
          $error("hit mismatch: expected %0b, actual %0b", want.hit, hit);
          fail_count++;
        end
        if (straddled !== want.straddled) begin
          $error("straddled mismatch: expected %0b, actual %0b", want.straddled, straddled);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
